>>> sv/rgbhsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsp_pkg
// Shared types and widths for the RGBA to HSP pixel converter.
// ----------------------------------------------------------------------------
package rgbhsp_pkg;

    localparam int HN_W = 20;   // hue dividend, 510*num + 6*d
    localparam int HD_W = 12;   // hue divisor, 12*d
    localparam int SN_W = 17;   // saturation dividend, 510*d + max
    localparam int SD_W = 9;    // saturation divisor, 2*max
    localparam int Q_W  = 28;   // 4 * weighted sum of squares
    localparam int NUM_CELLS = 8;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] hue_out;
        logic [7:0] saturation_out;
        logic [7:0] brightness_out;
        logic [7:0] alpha_out;
    } t_pix_out;

    // after the first front stage: squares and hue sector terms
    typedef struct packed {
        logic [15:0] sq_r;
        logic [15:0] sq_g;
        logic [15:0] sq_b;
        logic [7:0]  mx;
        logic [7:0]  d;
        logic [10:0] num;
        logic        grey;
        logic [7:0]  alpha;
    } t_stage_a;

    // word that travels down the cell chain
    typedef struct packed {
        logic [HN_W-1:0] hn;
        logic [HD_W-1:0] hd;
        logic [SN_W-1:0] sn;
        logic [SD_W-1:0] sd;
        logic [Q_W-1:0]  q4;
        logic [7:0]      hq;
        logic [7:0]      sq;
        logic [7:0]      p;
        logic [7:0]      alpha;
    } t_work;

endpackage

>>> sv/rgb_to_hsp_pixel_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsp_pixel_converter_unit
// RGBA pixel in, hue / saturation / perceived brightness / alpha out.
//
//   channel  signals                    role
//   input    i_valid, o_stall, i_pix    RGBA pixel transaction
//   output   o_valid, i_stall, o_pix    HSP pixel transaction
//
// One pixel per cycle while the output is not stalled: two front stages,
// then eight cells that each settle one bit of hue, saturation and brightness.
// Every stage holds its own valid, so a stalled output only backs up
// through full stages; bubbles are squeezed out.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsp_pixel_converter_unit
    import rgbhsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_pix_in  i_pix,
    output logic     o_valid,
    input  logic     i_stall,
    output t_pix_out o_pix
);

    logic  vld [NUM_CELLS+1];
    logic  rdy [NUM_CELLS+1];
    t_work wrk [NUM_CELLS+1];
    logic  front_ready;

    rgbhsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pix   (i_pix),
        .o_ready (front_ready),
        .o_valid (vld[0]),
        .o_work  (wrk[0]),
        .i_ready (rdy[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rgbhsp_cell #(.BIT(NUM_CELLS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .i_work  (wrk[k]),
            .o_ready (rdy[k]),
            .o_valid (vld[k+1]),
            .o_work  (wrk[k+1]),
            .i_ready (rdy[k+1])
        );
    end

    assign rdy[NUM_CELLS] = !i_stall;
    assign o_stall = !front_ready;
    assign o_valid = vld[NUM_CELLS];
    assign o_pix.hue_out        = wrk[NUM_CELLS].hq;
    assign o_pix.saturation_out = wrk[NUM_CELLS].sq;
    assign o_pix.brightness_out = wrk[NUM_CELLS].p;
    assign o_pix.alpha_out      = wrk[NUM_CELLS].alpha;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side is free");

    a_grey_hue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pix.saturation_out == 8'd0) |-> (o_pix.hue_out == 8'd0))
        else $error("zero saturation with nonzero hue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

>>> sv/rgbhsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsp_front
// Two registered stages: channel order, squares, then the dividends,
// divisors and scaled brightness sum that feed the cell chain.
// ----------------------------------------------------------------------------
module rgbhsp_front
    import rgbhsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_pix_in  i_pix,
    output logic     o_ready,
    output logic     o_valid,
    output t_work    o_work,
    input  logic     i_ready
);

    logic     r_valid_a, r_valid_b;
    t_stage_a r_a, n_a;
    t_work    r_b, n_b;
    logic     ready_a, ready_b;

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_valid_b;
    assign o_work  = r_b;

    always_comb begin
        logic [7:0] r, g, b;
        r = i_pix.red_in;
        g = i_pix.green_in;
        b = i_pix.blue_in;
        n_a = '0;
        n_a.sq_r  = r * r;
        n_a.sq_g  = g * g;
        n_a.sq_b  = b * b;
        n_a.alpha = i_pix.alpha_in;
        n_a.grey  = (r == g) && (r == b);
        // ties go to red, then green
        if (r >= g && r >= b) begin
            n_a.mx = r;
            if (b >= g) begin
                n_a.d   = r - g;
                n_a.num = 11'(6 * n_a.d) - 11'(b - g);
            end else begin
                n_a.d   = r - b;
                n_a.num = 11'(g - b);
            end
        end else if (g >= b) begin
            n_a.mx = g;
            if (r >= b) begin
                n_a.d   = g - b;
                n_a.num = 11'(2 * n_a.d) - 11'(r - b);
            end else begin
                n_a.d   = g - r;
                n_a.num = 11'(2 * n_a.d) + 11'(b - r);
            end
        end else begin
            n_a.mx = b;
            if (g >= r) begin
                n_a.d   = b - r;
                n_a.num = 11'(4 * n_a.d) - 11'(g - r);
            end else begin
                n_a.d   = b - g;
                n_a.num = 11'(4 * n_a.d) + 11'(r - g);
            end
        end
    end

    always_comb begin
        n_b = '0;
        n_b.alpha = r_a.alpha;
        n_b.q4 = Q_W'((Q_W'(299) * r_a.sq_r + Q_W'(587) * r_a.sq_g
                      + Q_W'(114) * r_a.sq_b) << 2);
        if (r_a.grey) begin
            n_b.hd = HD_W'(1);
            n_b.sd = SD_W'(1);
        end else begin
            n_b.hn = HN_W'(HN_W'(510) * r_a.num + HN_W'(6) * r_a.d);
            n_b.hd = HD_W'(HD_W'(12) * r_a.d);
            n_b.sn = SN_W'(SN_W'(510) * r_a.d + SN_W'(r_a.mx));
            n_b.sd = SD_W'({r_a.mx, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) r_valid_a <= i_valid;
            if (ready_b) r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid)   r_a <= n_a;
        if (ready_b && r_valid_a) r_b <= n_b;
    end

endmodule

>>> sv/rgbhsp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsp_cell
// One bit of every result: a restoring divide step for hue and saturation
// and a greedy square-root step for brightness.
// ----------------------------------------------------------------------------
module rgbhsp_cell
    import rgbhsp_pkg::*;
#(
    parameter int BIT = 7
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_ready,
    output logic  o_valid,
    output t_work o_work,
    input  logic  i_ready
);

    logic  r_valid;
    t_work r_work, n_work;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        logic [HN_W-1:0] hsh;
        logic [SN_W-1:0] ssh;
        logic [7:0]      cand;
        logic [8:0]      t;
        logic [17:0]     s;
        logic [Q_W-1:0]  m;
        n_work = i_work;
        hsh = HN_W'(i_work.hd) << BIT;
        ssh = SN_W'(i_work.sd) << BIT;
        if (i_work.hn >= hsh) begin
            n_work.hn      = i_work.hn - hsh;
            n_work.hq[BIT] = 1'b1;
        end
        if (i_work.sn >= ssh) begin
            n_work.sn      = i_work.sn - ssh;
            n_work.sq[BIT] = 1'b1;
        end
        // accept the bit if 1000*(2p-1)^2 stays within q4
        cand = i_work.p | (8'(1) << BIT);
        t    = {cand, 1'b0} - 9'd1;
        s    = t * t;
        m    = (Q_W'(s) << 10) - (Q_W'(s) << 4) - (Q_W'(s) << 3);
        if (m <= i_work.q4) n_work.p = cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_work <= n_work;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Pixel-level check of the RGBA to HSP converter. Directed corner pixels,
// then random pixels under several sender/receiver idling mixes; every
// output pixel is compared field by field with an integer prediction.
// ----------------------------------------------------------------------------
module tb_top
    import rgbhsp_pkg::*;
();

    localparam int LATENCY   = 10;
    localparam int IDLE_LIMIT = 2000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_pix_in  i_pix;
    logic     o_valid;
    logic     i_stall;
    t_pix_out o_pix;

    t_pix_out hsp_expected_q[$];
    int       error_count;
    int       idle_cycles;
    int       send_idle_pct;
    int       stall_pct;
    bit       timed_out;

    rgb_to_hsp_pixel_converter_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pix   (o_pix)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic t_pix_out predict_hsp(t_pix_in px);
        t_pix_out res;
        logic [63:0] r, g, b, mx, mn, d, num, q4, t;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        res.hue_out = '0;
        res.saturation_out = '0;
        if (!(r == g && r == b)) begin
            if (r >= g && r >= b) begin
                mx = r;
                if (b >= g) begin
                    mn = g; d = mx - mn; num = 6 * d - (b - g);
                end else begin
                    mn = b; d = mx - mn; num = g - b;
                end
            end else if (g >= r && g >= b) begin
                mx = g;
                if (r >= b) begin
                    mn = b; d = mx - mn; num = 2 * d - (r - b);
                end else begin
                    mn = r; d = mx - mn; num = 2 * d + (b - r);
                end
            end else begin
                mx = b;
                if (g >= r) begin
                    mn = r; d = mx - mn; num = 4 * d - (g - r);
                end else begin
                    mn = g; d = mx - mn; num = 4 * d + (r - g);
                end
            end
            res.hue_out = 8'(round_div(255 * num, 6 * d));
            res.saturation_out = 8'(round_div(255 * d, mx));
        end
        // largest p with (p - 1/2)^2 <= weighted mean square
        q4 = 4 * (299 * r * r + 587 * g * g + 114 * b * b);
        res.brightness_out = '0;
        for (int k = 1; k <= 255; k++) begin
            t = 2 * k - 1;
            if (1000 * t * t <= q4) res.brightness_out = 8'(k);
            else break;
        end
        res.alpha_out = px.alpha_in;
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // hold valid from one transaction to the next; idle cycles drop it
    task automatic send_pixel(t_pix_in px);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= px;
        hsp_expected_q.push_back(predict_hsp(px));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_pix_in make_pixel(int r, int g, int b, int a);
        t_pix_in px;
        px.red_in = 8'(r);
        px.green_in = 8'(g);
        px.blue_in = 8'(b);
        px.alpha_in = 8'(a);
        return px;
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // check each output transaction
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsp_expected_q.size() == 0) begin
                report_mismatch("unexpected output", 1, 0);
            end else begin
                want = hsp_expected_q.pop_front();
                if (o_pix.hue_out !== want.hue_out)
                    report_mismatch("hue", int'(o_pix.hue_out), int'(want.hue_out));
                if (o_pix.saturation_out !== want.saturation_out)
                    report_mismatch("saturation", int'(o_pix.saturation_out),
                                    int'(want.saturation_out));
                if (o_pix.brightness_out !== want.brightness_out)
                    report_mismatch("brightness", int'(o_pix.brightness_out),
                                    int'(want.brightness_out));
                if (o_pix.alpha_out !== want.alpha_out)
                    report_mismatch("alpha", int'(o_pix.alpha_out), int'(want.alpha_out));
            end
        end
    end

    // count cycles with no accepted transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_corner_pixels();
        int corners[24][4] = '{
            '{0, 0, 0, 0}, '{255, 255, 255, 255}, '{128, 128, 128, 170},
            '{255, 0, 0, 85}, '{0, 255, 0, 1}, '{0, 0, 255, 254},
            '{255, 0, 255, 0}, '{255, 255, 0, 128}, '{0, 255, 255, 127},
            '{200, 50, 50, 3}, '{200, 50, 60, 4}, '{200, 60, 50, 5},
            '{100, 100, 40, 6}, '{40, 100, 100, 7}, '{100, 40, 100, 8},
            '{50, 200, 60, 9}, '{60, 200, 50, 10}, '{60, 50, 200, 11},
            '{50, 60, 200, 12}, '{1, 0, 0, 13}, '{0, 1, 0, 14}, '{0, 0, 1, 15},
            '{255, 254, 254, 16}, '{170, 85, 0, 240}
        };
        foreach (corners[i])
            send_pixel(make_pixel(corners[i][0], corners[i][1], corners[i][2],
                                  corners[i][3]));
    endtask

    task automatic test_random_pixels(int count, int idle_pct, int stl_pct);
        int v;
        t_pix_in px;
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        for (int n = 0; n < count; n++) begin
            px = t_pix_in'($urandom);
            v = $urandom_range(9);
            // bias toward ties and near-grey pixels
            if (v == 0) px.green_in = px.red_in;
            else if (v == 1) px.blue_in = px.red_in;
            else if (v == 2) px.blue_in = px.green_in;
            else if (v == 3) begin
                px.green_in = px.red_in ^ 8'($urandom_range(1));
                px.blue_in  = px.red_in;
            end
            send_pixel(px);
        end
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (hsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pix         = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_pixels();
        test_random_pixels(460, 0, 0);
        test_random_pixels(460, 45, 0);
        test_random_pixels(460, 0, 45);
        test_random_pixels(460, 12, 12);
        send_idle_pct = 0;
        stall_pct     = 0;
        drain_pipeline();

        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
